FILE: design/dltb_pkg.sv
// ----------------------------------------------------------------------------
// dltb_pkg
// Shared types, codes and constants of the delta-list timer bank.
// ----------------------------------------------------------------------------
package dltb_pkg;

    localparam int ID_W      = 5;
    localparam int PER_W     = 32;
    localparam int TPU_W     = 16;
    localparam int TICK_W    = 32;
    localparam int ST_W      = 2;
    localparam int TIMERS_DEF = 16;
    localparam logic [TPU_W-1:0] TPU_RST = 16'd1000;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_RESTART = 3'd4,
        OP_DELETE  = 3'd5,
        OP_QUERY   = 3'd6,
        OP_BAD     = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        SL_FREE = 2'd0,
        SL_STOP = 2'd1,
        SL_RUN  = 2'd2
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_DIV,
        S_CRT,
        S_RST,
        S_RST_GO,
        S_REM,
        S_INS,
        S_WALK,
        S_RESP,
        S_XCHK,
        S_XACT,
        S_XEV,
        S_XEND
    } t_fsm;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [ID_W-1:0]  timer_id;
        logic [PER_W-1:0] period_us;
        logic             periodic;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic              status;
        logic [ID_W-1:0]   new_id;
        logic [ID_W-1:0]   event_timer;
        logic [ST_W-1:0]   timer_state;
        logic [TICK_W-1:0] ticks_seen;
        logic              last;
    } t_out;

    // reload plus one, held at all ones
    function automatic logic [PER_W-1:0] sat_inc(input logic [PER_W-1:0] v);
        sat_inc = (v == '1) ? v : v + PER_W'(1);
    endfunction

endpackage

FILE: design/delta_list_timer_bank.sv
// ----------------------------------------------------------------------------
// delta_list_timer_bank
// Timer bank with a delta-ordered list of running timers and a command port.
// ----------------------------------------------------------------------------
// query and delete pass decode, then the response state; stop of a running timer also unlinks it
// start also walks the list to insert; create waits for the divider before its response
// restart waits for the divider, then list removal if running and a walk; a tick without
// expiry gives no result; a tick with expiries removes each one, walking the list for periodic ones
// one item at a time; input stalls from transfer until any last result is registered
// synchronous reset clears all slots, the list and the tick count; no clearing pass
module delta_list_timer_bank #(
    parameter int TIMERS = dltb_pkg::TIMERS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  dltb_pkg::t_in              i_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output dltb_pkg::t_out             o_out,
    input  logic                       i_cfg_wr_en,
    input  logic [dltb_pkg::TPU_W-1:0] i_cfg_wr_data
);
    import dltb_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic [PER_W-1:0] r_delta  [TIMERS];
    logic [PER_W-1:0] n_delta  [TIMERS];
    logic [PER_W-1:0] r_reload [TIMERS];
    logic [PER_W-1:0] n_reload [TIMERS];
    logic             r_per    [TIMERS];
    logic             n_per    [TIMERS];
    t_slot            r_slot   [TIMERS];
    t_slot            n_slot   [TIMERS];
    logic             r_delp   [TIMERS];
    logic             n_delp   [TIMERS];
    logic [ID_W-1:0]  r_next   [TIMERS];
    logic [ID_W-1:0]  n_next   [TIMERS];
    logic [ID_W-1:0]  r_prev   [TIMERS];
    logic [ID_W-1:0]  n_prev   [TIMERS];

    logic [ID_W-1:0]   r_head, n_head;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [TPU_W-1:0]  r_tpu, n_tpu;
    t_fsm              r_fsm, n_fsm;
    t_fsm              r_ret, n_ret;
    t_op               r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [PER_W-1:0]  r_period, n_period;
    logic              r_pflag, n_pflag;
    logic [IW-1:0]     r_cur, n_cur;
    logic [ID_W-1:0]   r_walk, n_walk;
    logic [PER_W-1:0]  r_r, n_r;
    logic              r_status, n_status;
    logic [ID_W-1:0]   r_nid, n_nid;
    logic [ID_W-1:0]   r_evt, n_evt;
    logic [ST_W-1:0]   r_tst, n_tst;
    logic              r_hold_v, n_hold_v;
    logic [ID_W-1:0]   r_hold_id, n_hold_id;
    logic [ST_W-1:0]   r_hold_st, n_hold_st;
    t_out              r_out, n_out;
    logic              r_ovalid, n_ovalid;

    logic             div_start;
    logic             div_done;
    logic [PER_W-1:0] div_q;
    logic [PER_W-1:0] clamp_q;
    logic [PER_W-1:0] rr;
    logic [TPU_W-1:0] dvs;
    logic             id_ok;
    logic [IW-1:0]    id_idx;
    logic             found;
    logic [IW-1:0]    fidx;
    logic             out_free;
    logic [IW-1:0]    h_idx;
    logic [IW-1:0]    w_idx;
    logic [ID_W-1:0]  pv;
    logic [ID_W-1:0]  nx;
    logic [ID_W-1:0]  cur_link;

    function automatic logic [IW-1:0] l2i(input logic [ID_W-1:0] l);
        logic [ID_W-1:0] d;
        d = l - ID_W'(1);
        l2i = d[IW-1:0];
    endfunction

    dltb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_period),
        .i_divisor  (r_tpu),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_delta  = r_delta;
        n_reload = r_reload;
        n_per    = r_per;
        n_slot   = r_slot;
        n_delp   = r_delp;
        n_next   = r_next;
        n_prev   = r_prev;
        n_head    = r_head;
        n_ticks   = r_ticks;
        n_tpu     = i_cfg_wr_en ? i_cfg_wr_data : r_tpu;
        n_fsm     = r_fsm;
        n_ret     = r_ret;
        n_op      = r_op;
        n_id      = r_id;
        n_period  = r_period;
        n_pflag   = r_pflag;
        n_cur     = r_cur;
        n_walk    = r_walk;
        n_r       = r_r;
        n_status  = r_status;
        n_nid     = r_nid;
        n_evt     = r_evt;
        n_tst     = r_tst;
        n_hold_v  = r_hold_v;
        n_hold_id = r_hold_id;
        n_hold_st = r_hold_st;
        n_out     = r_out;
        n_ovalid  = r_ovalid && i_stall;
        div_start = 1'b0;

        out_free = !r_ovalid || !i_stall;
        dvs      = (r_tpu == '0) ? TPU_W'(1) : r_tpu;
        id_ok    = (r_id != '0) && (int'(r_id) <= TIMERS);
        id_idx   = l2i(r_id);
        h_idx    = l2i(r_head);
        w_idx    = l2i(r_walk);
        cur_link = ID_W'(r_cur) + ID_W'(1);
        clamp_q  = (div_q == '0) ? PER_W'(1) : div_q;
        rr       = r_r - r_delta[w_idx];
        pv       = r_prev[r_cur];
        nx       = r_next[r_cur];
        found    = 1'b0;
        fidx     = '0;
        for (int i = 0; i < TIMERS; i++) begin
            if (!found && r_slot[i] == SL_FREE) begin
                found = 1'b1;
                fidx  = IW'(i);
            end
        end

        case (r_fsm)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = t_op'(i_in.opcode);
                    n_id     = i_in.timer_id;
                    n_period = i_in.period_us;
                    n_pflag  = i_in.periodic;
                    n_fsm    = S_DEC;
                end
            end
            S_DEC: begin
                n_status = 1'b1;
                n_nid    = '0;
                n_evt    = '0;
                n_tst    = '0;
                n_cur    = id_idx;
                n_fsm    = S_RESP;
                case (r_op)
                    OP_TICK: begin
                        n_ticks = r_ticks + TICK_W'(1);
                        n_hold_v = 1'b0;
                        if (r_head == '0) begin
                            n_fsm = S_IDLE;
                        end else if (r_delta[h_idx] > PER_W'(1)) begin
                            n_delta[h_idx] = r_delta[h_idx] - PER_W'(1);
                            n_fsm = S_IDLE;
                        end else begin
                            n_delta[h_idx] = '0;
                            n_fsm = S_XCHK;
                        end
                    end
                    OP_CREATE: begin
                        if (r_period >= PER_W'(dvs) && found) begin
                            n_cur     = fidx;
                            div_start = 1'b1;
                            n_ret     = S_CRT;
                            n_fsm     = S_DIV;
                        end
                    end
                    OP_QUERY: begin
                        n_status = !id_ok;
                        n_evt    = r_id;
                        n_tst    = id_ok ? r_slot[id_idx] : SL_FREE;
                    end
                    default: begin
                        if (id_ok && r_slot[id_idx] != SL_FREE) begin
                            case (r_op)
                                OP_START: begin
                                    if (r_slot[id_idx] == SL_STOP) begin
                                        n_status = 1'b0;
                                        n_delta[id_idx] = sat_inc(r_reload[id_idx]);
                                        n_slot[id_idx]  = SL_RUN;
                                        n_ret = S_RESP;
                                        n_fsm = S_INS;
                                    end
                                end
                                OP_STOP: begin
                                    n_status = 1'b0;
                                    if (r_slot[id_idx] == SL_RUN) begin
                                        n_slot[id_idx] = SL_STOP;
                                        n_ret = S_RESP;
                                        n_fsm = S_REM;
                                    end
                                end
                                OP_RESTART: begin
                                    div_start = 1'b1;
                                    n_ret = S_RST;
                                    n_fsm = S_DIV;
                                end
                                OP_DELETE: begin
                                    n_status = 1'b0;
                                    if (r_slot[id_idx] == SL_STOP) begin
                                        n_slot[id_idx] = SL_FREE;
                                    end else begin
                                        n_delp[id_idx] = 1'b1;
                                    end
                                end
                                default: begin
                                    n_status = 1'b1;
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_fsm = r_ret;
                end
            end
            S_CRT: begin
                n_slot[r_cur]   = SL_STOP;
                n_per[r_cur]    = r_pflag;
                n_delp[r_cur]   = 1'b0;
                n_reload[r_cur] = div_q;
                n_delta[r_cur]  = div_q + PER_W'(1);
                n_status = 1'b0;
                n_nid    = cur_link;
                n_fsm    = S_RESP;
            end
            S_RST: begin
                if (r_slot[r_cur] == SL_RUN) begin
                    n_slot[r_cur] = SL_STOP;
                    n_ret = S_RST_GO;
                    n_fsm = S_REM;
                end else begin
                    n_fsm = S_RST_GO;
                end
            end
            S_RST_GO: begin
                n_reload[r_cur] = clamp_q;
                n_delta[r_cur]  = sat_inc(clamp_q);
                n_slot[r_cur]   = SL_RUN;
                n_status = 1'b0;
                n_ret    = S_RESP;
                n_fsm    = S_INS;
            end
            S_REM: begin
                if (nx != '0) begin
                    n_delta[l2i(nx)] = r_delta[l2i(nx)] + r_delta[r_cur];
                    n_prev[l2i(nx)]  = pv;
                end
                if (pv != '0) begin
                    n_next[l2i(pv)] = nx;
                end else begin
                    n_head = nx;
                end
                n_prev[r_cur] = '0;
                n_next[r_cur] = '0;
                n_fsm = r_ret;
            end
            S_INS: begin
                n_prev[r_cur] = '0;
                n_next[r_cur] = '0;
                if (r_head == '0) begin
                    n_head = cur_link;
                    n_fsm  = r_ret;
                end else begin
                    n_walk = r_head;
                    n_r    = r_delta[r_cur];
                    n_fsm  = S_WALK;
                end
            end
            S_WALK: begin
                if (r_r <= r_delta[w_idx]) begin
                    n_prev[r_cur] = r_prev[w_idx];
                    n_next[r_cur] = r_walk;
                    n_prev[w_idx] = cur_link;
                    if (r_prev[w_idx] != '0) begin
                        n_next[l2i(r_prev[w_idx])] = cur_link;
                    end else begin
                        n_head = cur_link;
                    end
                    n_delta[r_cur] = r_r;
                    n_delta[w_idx] = r_delta[w_idx] - r_r;
                    n_fsm = r_ret;
                end else if (r_next[w_idx] == '0) begin
                    n_next[w_idx]  = cur_link;
                    n_prev[r_cur]  = r_walk;
                    n_delta[r_cur] = rr;
                    n_fsm = r_ret;
                end else begin
                    n_r    = rr;
                    n_walk = r_next[w_idx];
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out = '{kind: 1'b0, status: r_status, new_id: r_nid,
                              event_timer: r_evt, timer_state: r_tst,
                              ticks_seen: r_ticks, last: 1'b1};
                    n_ovalid = 1'b1;
                    n_fsm    = S_IDLE;
                end
            end
            S_XCHK: begin
                if (r_head != '0 && r_delta[h_idx] == '0) begin
                    n_cur = h_idx;
                    n_ret = S_XACT;
                    n_fsm = S_REM;
                end else begin
                    n_fsm = S_XEND;
                end
            end
            S_XACT: begin
                if (r_delp[r_cur]) begin
                    n_slot[r_cur] = SL_FREE;
                    n_fsm = S_XCHK;
                end else if (!r_per[r_cur]) begin
                    n_slot[r_cur] = SL_STOP;
                    n_tst = SL_STOP;
                    n_fsm = S_XEV;
                end else begin
                    n_delta[r_cur] = r_reload[r_cur];
                    n_tst = SL_RUN;
                    n_ret = S_XEV;
                    n_fsm = S_INS;
                end
            end
            S_XEV: begin
                // one event held back so the final one can carry last
                if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_out = '{kind: 1'b1, status: 1'b0, new_id: '0,
                                  event_timer: r_hold_id, timer_state: r_hold_st,
                                  ticks_seen: r_ticks, last: 1'b0};
                        n_ovalid = 1'b1;
                    end
                    n_hold_v  = 1'b1;
                    n_hold_id = cur_link;
                    n_hold_st = r_tst;
                    n_fsm     = S_XCHK;
                end
            end
            S_XEND: begin
                if (!r_hold_v) begin
                    n_fsm = S_IDLE;
                end else if (out_free) begin
                    n_out = '{kind: 1'b1, status: 1'b0, new_id: '0,
                              event_timer: r_hold_id, timer_state: r_hold_st,
                              ticks_seen: r_ticks, last: 1'b1};
                    n_ovalid = 1'b1;
                    n_hold_v = 1'b0;
                    n_fsm    = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMERS; i++) begin
                r_delta[i]  <= '0;
                r_reload[i] <= '0;
                r_per[i]    <= 1'b0;
                r_slot[i]   <= SL_FREE;
                r_delp[i]   <= 1'b0;
                r_next[i]   <= '0;
                r_prev[i]   <= '0;
            end
            r_head   <= '0;
            r_ticks  <= '0;
            r_tpu    <= TPU_RST;
            r_fsm    <= S_IDLE;
            r_ret    <= S_IDLE;
            r_hold_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_delta  <= n_delta;
            r_reload <= n_reload;
            r_per    <= n_per;
            r_slot   <= n_slot;
            r_delp   <= n_delp;
            r_next   <= n_next;
            r_prev   <= n_prev;
            r_head   <= n_head;
            r_ticks  <= n_ticks;
            r_tpu    <= n_tpu;
            r_fsm    <= n_fsm;
            r_ret    <= n_ret;
            r_hold_v <= n_hold_v;
            r_ovalid <= n_ovalid;
        end
        r_op      <= n_op;
        r_id      <= n_id;
        r_period  <= n_period;
        r_pflag   <= n_pflag;
        r_cur     <= n_cur;
        r_walk    <= n_walk;
        r_r       <= n_r;
        r_status  <= n_status;
        r_nid     <= n_nid;
        r_evt     <= n_evt;
        r_tst     <= n_tst;
        r_hold_id <= n_hold_id;
        r_hold_st <= n_hold_st;
        r_out     <= n_out;
    end

    assign o_stall = (r_fsm != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_head) <= TIMERS)
        else $error("list head out of range");

    a_resp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_out.kind) |-> r_out.last)
        else $error("command response without last");

    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_fsm == S_DEC))
        else $error("transfer not decoded");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_fsm == S_DIV))
        else $error("divider finished outside wait state");

endmodule

FILE: design/dltb_div.sv
// ----------------------------------------------------------------------------
// dltb_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit.
// ----------------------------------------------------------------------------
module dltb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dltb_pkg::PER_W-1:0] i_dividend,
    input  logic [dltb_pkg::TPU_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [dltb_pkg::PER_W-1:0] o_quotient
);
    import dltb_pkg::*;

    localparam int CW = $clog2(PER_W);

    logic [TPU_W-1:0] r_dvs, n_dvs;
    logic [TPU_W-1:0] r_rem, n_rem;
    logic [PER_W-1:0] r_quo, n_quo;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [TPU_W:0]   rem_sh;
    logic [TPU_W:0]   rem_sub;

    always_comb begin
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        rem_sh  = {r_rem, r_quo[PER_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        if (i_start) begin
            n_dvs  = (i_divisor == '0) ? TPU_W'(1) : i_divisor;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = rem_sub[TPU_W-1:0];
                n_quo = {r_quo[PER_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[TPU_W-1:0];
                n_quo = {r_quo[PER_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(PER_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvs <= n_dvs;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Timer bank check: a directed command table followed by random command and
// tick traffic under several tick periods and idle patterns, every response
// and expiry compared against table values or an in-bench model of the timer list.
// ----------------------------------------------------------------------------
module testbench;
    import dltb_pkg::*;

    localparam int NT = TIMERS_DEF;

    typedef struct {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] per_us;
        logic             periodic;
        bit               typed;
        t_out             want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_in                 i_in;
    logic                o_valid;
    logic                i_stall;
    t_out                o_out;
    logic                i_cfg_wr_en;
    logic [TPU_W-1:0]    i_cfg_wr_data;

    // timer list model
    logic [31:0]      m_rem [NT];
    logic [31:0]      m_rld [NT];
    bit               m_per [NT];
    bit               m_del [NT];
    t_slot            m_st  [NT];
    int               m_nxt [NT];
    int               m_prv [NT];
    int               m_head;
    logic [NT-1:0]    m_used;
    logic [31:0]      m_ticks;
    logic [TPU_W-1:0] m_tpu;

    t_out             pending_results [$];
    t_out             step_results [$];
    t_row             rows [$];
    int               n_errors = 0;
    int               idle_mode = 0;

    delta_list_timer_bank u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in          (i_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] tick_div();
        return (m_tpu == 0) ? 32'd1 : 32'(m_tpu);
    endfunction

    function automatic void list_insert(int i);
        logic [31:0] r;
        int p;
        int g;
        int n;
        int pv;
        r = m_rem[i];
        p = m_head;
        g = 0;
        m_prv[i] = 0;
        m_nxt[i] = 0;
        if (p == 0) begin
            m_head = i + 1;
            return;
        end
        while (p != 0 && g < NT) begin
            g++;
            n = p - 1;
            if (r <= m_rem[n]) begin
                pv = m_prv[n];
                m_prv[i] = pv;
                m_nxt[i] = p;
                m_prv[n] = i + 1;
                if (pv != 0) m_nxt[pv-1] = i + 1;
                else m_head = i + 1;
                m_rem[i] = r;
                m_rem[n] -= r;
                return;
            end
            r -= m_rem[n];
            if (m_nxt[n] == 0) begin
                m_nxt[n] = i + 1;
                m_prv[i] = p;
                m_rem[i] = r;
                return;
            end
            p = m_nxt[n];
        end
    endfunction

    function automatic void list_remove(int i);
        int p;
        int n;
        p = m_prv[i];
        n = m_nxt[i];
        if (n != 0) begin
            m_rem[n-1] += m_rem[i];
            m_prv[n-1] = p;
        end
        if (p != 0) m_nxt[p-1] = n;
        else m_head = n;
        m_prv[i] = 0;
        m_nxt[i] = 0;
    endfunction

    function automatic void arm_timer(int i);
        m_rem[i] = (m_rld[i] == 32'hFFFF_FFFF) ? m_rld[i] : m_rld[i] + 1;
        m_st[i] = SL_RUN;
        list_insert(i);
    endfunction

    function automatic void add_result(logic kind, logic status, int nid, int ev, t_slot st);
        t_out r;
        r.kind = kind;
        r.status = status;
        r.new_id = ID_W'(nid);
        r.event_timer = ID_W'(ev);
        r.timer_state = st;
        r.ticks_seen = m_ticks;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < NT; i++) begin
            m_rem[i] = 0;
            m_rld[i] = 0;
            m_per[i] = 0;
            m_del[i] = 0;
            m_st[i] = SL_FREE;
            m_nxt[i] = 0;
            m_prv[i] = 0;
        end
        m_head = 0;
        m_used = '0;
        m_ticks = 0;
        m_tpu = TPU_RST;
    endfunction

    // fills step_results with what one command or tick produces
    function automatic void predict_timers(t_in it);
        t_op op;
        int id;
        bit idok;
        int t;
        bit fail;
        int g;
        int k;
        int n;
        int nid;
        logic [31:0] ratio;
        op = t_op'(it.opcode);
        id = it.timer_id;
        idok = (id >= 1 && id <= NT);
        t = idok ? id - 1 : 0;
        fail = 1;
        step_results.delete();
        if (op == OP_TICK) begin
            m_ticks++;
            if (m_head == 0) return;
            if (m_rem[m_head-1] > 1) begin
                m_rem[m_head-1]--;
                return;
            end
            m_rem[m_head-1] = 0;
            g = 0;
            k = 0;
            while (m_head != 0 && m_rem[m_head-1] == 0 && g < 2 * NT && k < NT) begin
                g++;
                n = m_head - 1;
                list_remove(n);
                if (m_del[n]) begin
                    m_st[n] = SL_FREE;
                    m_used[n] = 1'b0;
                end else if (!m_per[n]) begin
                    m_st[n] = SL_STOP;
                    add_result(1'b1, 1'b0, 0, n + 1, SL_STOP);
                    k++;
                end else begin
                    m_rem[n] = m_rld[n];
                    list_insert(n);
                    add_result(1'b1, 1'b0, 0, n + 1, SL_RUN);
                    k++;
                end
            end
            if (k > 0) step_results[k-1].last = 1'b1;
            return;
        end
        if (op == OP_CREATE) begin
            nid = 0;
            if (it.period_us >= tick_div()) begin
                for (int i = 0; i < NT; i++) begin
                    if (!m_used[i]) begin
                        m_used[i] = 1'b1;
                        m_per[i] = it.periodic;
                        m_st[i] = SL_STOP;
                        m_del[i] = 0;
                        m_rld[i] = it.period_us / tick_div();
                        m_nxt[i] = 0;
                        m_prv[i] = 0;
                        nid = i + 1;
                        break;
                    end
                end
            end
            add_result(1'b0, nid == 0, nid, 0, SL_FREE);
        end else if (op == OP_QUERY) begin
            add_result(1'b0, !idok, 0, id, idok ? m_st[t] : SL_FREE);
        end else begin
            if (idok && m_st[t] != SL_FREE) begin
                case (op)
                    OP_START: begin
                        if (m_st[t] == SL_STOP) begin
                            arm_timer(t);
                            fail = 0;
                        end
                    end
                    OP_STOP: begin
                        if (m_st[t] == SL_RUN) begin
                            m_st[t] = SL_STOP;
                            list_remove(t);
                        end
                        fail = 0;
                    end
                    OP_RESTART: begin
                        ratio = it.period_us / tick_div();
                        if (m_st[t] == SL_RUN) begin
                            m_st[t] = SL_STOP;
                            list_remove(t);
                        end
                        m_rld[t] = (ratio == 0) ? 32'd1 : ratio;
                        arm_timer(t);
                        fail = 0;
                    end
                    OP_DELETE: begin
                        if (m_st[t] == SL_STOP) begin
                            m_st[t] = SL_FREE;
                            m_used[t] = 1'b0;
                        end else begin
                            m_del[t] = 1;
                        end
                        fail = 0;
                    end
                    default: ;
                endcase
            end
            add_result(1'b0, fail, 0, 0, SL_FREE);
        end
        step_results[0].last = 1'b1;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        n_errors++;
    endtask

    // receiver side stall pattern
    always @(posedge i_clk) begin
        if (idle_mode >= 2) i_stall <= ($urandom_range(0, 99) < ((idle_mode == 2) ? 46 : 24));
        else i_stall <= 1'b0;
    end

    // outputs settle after the edge, so sample them at the falling edge
    always @(negedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_out.event_timer, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out.kind !== want.kind) report_mismatch("kind", o_out.kind, want.kind);
                if (o_out.status !== want.status)
                    report_mismatch("status", o_out.status, want.status);
                if (o_out.new_id !== want.new_id)
                    report_mismatch("new_id", o_out.new_id, want.new_id);
                if (o_out.event_timer !== want.event_timer)
                    report_mismatch("event_timer", o_out.event_timer, want.event_timer);
                if (o_out.timer_state !== want.timer_state)
                    report_mismatch("timer_state", o_out.timer_state, want.timer_state);
                if (o_out.ticks_seen !== want.ticks_seen)
                    report_mismatch("ticks_seen", o_out.ticks_seen, want.ticks_seen);
                if (o_out.last !== want.last) report_mismatch("last", o_out.last, want.last);
            end
        end
    end

    task automatic send_item(t_in it, bit typed, t_out want);
        bit taken;
        if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(0, 99) < ((idle_mode == 1) ? 46 : 24)) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_in <= it;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        predict_timers(it);
        if (typed) pending_results.push_back(want);
        else foreach (step_results[j]) pending_results.push_back(step_results[j]);
    endtask

    task automatic write_tick_period(logic [TPU_W-1:0] val);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        m_tpu = val;
    endtask

    function automatic void add_row(t_op op, int id, logic [31:0] per_us, bit periodic,
                                    bit typed = 0, logic status = 0, int nid = 0,
                                    int ev = 0, t_slot st = SL_FREE);
        t_row r;
        r.op = op;
        r.id = ID_W'(id);
        r.per_us = per_us;
        r.periodic = periodic;
        r.typed = typed;
        r.want = '{1'b0, status, ID_W'(nid), ID_W'(ev), st, 32'd0, 1'b1};
        rows.push_back(r);
    endfunction

    function automatic t_in random_item();
        t_in it;
        int sel;
        logic [31:0] d;
        d = tick_div();
        sel = $urandom_range(0, 99);
        it.opcode = (sel < 40) ? OP_TICK : (sel < 53) ? OP_CREATE : (sel < 65) ? OP_START :
                    (sel < 71) ? OP_STOP : (sel < 80) ? OP_RESTART : (sel < 87) ? OP_DELETE :
                    (sel < 96) ? OP_QUERY : OP_BAD;
        sel = $urandom_range(0, 99);
        it.timer_id = (sel < 80) ? ID_W'($urandom_range(1, NT)) :
                      (sel < 88) ? ID_W'(0) : ID_W'($urandom_range(NT + 1, 31));
        sel = $urandom_range(0, 99);
        if (sel < 75) it.period_us = d * $urandom_range(1, 5) + $urandom_range(0, d - 1);
        else if (sel < 88) it.period_us = $urandom_range(0, d - 1);
        else it.period_us = $urandom;
        it.periodic = $urandom_range(0, 1);
        return it;
    endfunction

    initial begin
        t_in it;
        t_out none;
        logic [TPU_W-1:0] periods [4] = '{16'd1, 16'd65535, 16'd0, 16'd37};
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        none = '0;
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(OP_QUERY, 1, 0, 0, 1, 1'b0, 0, 1, SL_FREE);
        add_row(OP_QUERY, 0, 0, 0, 1, 1'b1, 0, 0, SL_FREE);
        add_row(OP_QUERY, 31, 0, 0, 1, 1'b1, 0, 31, SL_FREE);
        add_row(OP_BAD, 1, 32'hFFFF_FFFF, 1, 1, 1'b1);
        add_row(OP_STOP, 1, 0, 0, 1, 1'b1);
        add_row(OP_CREATE, 0, 999, 0, 1, 1'b1, 0);
        add_row(OP_CREATE, 0, 1000, 0, 1, 1'b0, 1);
        add_row(OP_CREATE, 31, 32'hFFFF_FFFF, 1, 1, 1'b0, 2);
        add_row(OP_CREATE, 0, 3500, 1, 1, 1'b0, 3);
        add_row(OP_START, 1, 0, 0);
        add_row(OP_START, 1, 0, 0);
        add_row(OP_START, 3, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_RESTART, 3, 0, 0);
        add_row(OP_RESTART, 1, 2000, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_DELETE, 3, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_QUERY, 3, 0, 0);
        add_row(OP_DELETE, 1, 0, 0);
        add_row(OP_DELETE, 17, 0, 0);
        add_row(OP_START, 2, 0, 0);
        add_row(OP_STOP, 2, 0, 0);
        foreach (rows[r]) begin
            it.opcode = rows[r].op;
            it.timer_id = rows[r].id;
            it.period_us = rows[r].per_us;
            it.periodic = rows[r].periodic;
            send_item(it, rows[r].typed, rows[r].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            write_tick_period(periods[ph]);
            idle_mode = ph;
            for (int n = 0; n < 80; n++) send_item(random_item(), 0, none);
        end
        write_tick_period(TPU_RST);
        idle_mode = 3;
        for (int n = 0; n < 20; n++) send_item(random_item(), 0, none);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
